/* hw/rtl/gecc_pkg.sv */
// ----------------------------------------------------------------------------
// gecc_pkg
// Shared widths, constants and types of the enclosed gold cell counter.
// ----------------------------------------------------------------------------
package gecc_pkg;

  localparam int unsigned CFG_W      = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned VALUE_W    = 8;
  localparam int unsigned GOLD_W     = 11;
  localparam int unsigned ENC_W      = 10;
  localparam int unsigned MAX_SIDE_DEF = 32;

  localparam logic [VALUE_W-1:0] GOLD_VALUE   = 8'd9;
  localparam logic [CFG_W-1:0]   SIDE_RESET   = 6'd32;
  localparam logic [GOLD_W-1:0]  GOLD_MAX     = 11'd2047;
  localparam logic [ENC_W-1:0]   ENC_MAX      = 10'd1023;

  // Register indexes on the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT    = 2'd0,
    REG_COLUMN_COUNT = 2'd1
  } cfg_reg_e;

  // Per-cell control carried from the input register to the evaluator
  typedef struct packed {
    logic gold;       // cell equals the gold value
    logic interior;   // row >= 2 and column >= 2: window test applies
    logic row_end;    // last column of a row
    logic frame_end;  // last cell of the grid
  } cell_ctl_t;

endpackage

/* hw/rtl/gecc_cell_if.sv */
// ----------------------------------------------------------------------------
// gecc_cell_if
// Input word channel: one grid cell per word.
// ----------------------------------------------------------------------------
interface gecc_cell_if;
  import gecc_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

/* hw/rtl/gecc_result_if.sv */
// ----------------------------------------------------------------------------
// gecc_result_if
// Result word channel: both grid counts in one word.
// ----------------------------------------------------------------------------
interface gecc_result_if;
  import gecc_pkg::*;

  logic              valid;
  logic              ready;
  logic [GOLD_W-1:0] gold_total;
  logic [ENC_W-1:0]  enclosed_gold;

  modport source (output valid, output gold_total, output enclosed_gold, input ready);
  modport sink   (input valid, input gold_total, input enclosed_gold, output ready);
endinterface

/* hw/rtl/gecc_cfg_if.sv */
// ----------------------------------------------------------------------------
// gecc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface gecc_cfg_if;
  import gecc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/grid_enclosed_cell_counter.sv */
// ----------------------------------------------------------------------------
// grid_enclosed_cell_counter
// Counts gold cells (value 9) of a raster grid and the interior gold cells
// whose whole 3x3 neighbourhood is gold; reports both with the final cell.
// ----------------------------------------------------------------------------
// Throughput: one cell word per cycle while no final cell waits on a full
//   result register; the line store takes one read and one write per cell.
// Result path: the grid's final cell passes the input register, then the
//   result register, which drives the result word.
// Reset: grid size 32 x 32, position, window and counters cleared. The line
//   store is not cleared; an entry is used only after this grid wrote it.
// ----------------------------------------------------------------------------
module grid_enclosed_cell_counter #(
  parameter int unsigned MAX_SIDE = gecc_pkg::MAX_SIDE_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  gecc_cfg_if.sink      cfg_i,
  gecc_cell_if.sink     cell_i,
  gecc_result_if.source result_o
);
  import gecc_pkg::*;

  localparam int unsigned PW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

  logic          cfg_we;
  logic          cfg_restart;
  logic [PW-1:0] rd_col;
  logic          s1_valid;
  cell_ctl_t     s1_ctl;
  logic [PW-1:0] s1_col;
  logic          s1_fire;
  logic          in_fire;
  logic [1:0]    line_wdata;
  logic [1:0]    ram_rdata;
  logic [1:0]    above;
  logic          byp_q;
  logic [1:0]    byp_data_q;

  // Config always taken; the user, not the block, sends it only when idle
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  // Only a write to a size register restarts the grid; other indexes drop
  assign cfg_restart = cfg_we && ((cfg_i.index == REG_ROW_COUNT) ||
                                  (cfg_i.index == REG_COLUMN_COUNT));

  // Raster position, size registers and the input register
  gecc_scan #(
    .MAX_SIDE (MAX_SIDE),
    .PW       (PW)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .in_valid_i   (cell_i.valid),
    .in_ready_o   (cell_i.ready),
    .cell_value_i (cell_i.cell_value),
    .rd_col_o     (rd_col),
    .s1_valid_o   (s1_valid),
    .s1_ctl_o     (s1_ctl),
    .s1_col_o     (s1_col),
    .s1_fire_i    (s1_fire)
  );

  assign in_fire = cell_i.valid && cell_i.ready;

  // Line store: two rows of gold flags per column. Read the entry of the
  // incoming cell's column as the word enters the input register; write
  // the aged entry back when that cell leaves the input register.
  gecc_ram #(
    .WIDTH (2),
    .DEPTH (MAX_SIDE),
    .AW    (PW)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col),
    .wdata_i (line_wdata),
    .re_i    (in_fire),
    .raddr_i (rd_col),
    .rdata_o (ram_rdata)
  );

  // Single-column grids write and read the same entry on one edge: forward
  // the write data, since the RAM returns the old contents.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (in_fire) begin
      byp_q <= s1_fire && (s1_col == rd_col);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byp_data_q <= line_wdata;
    end
  end

  assign above = byp_q ? byp_data_q : ram_rdata;

  // Window test, counters and the result register
  gecc_eval u_eval (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .restart_i       (cfg_restart),
    .s1_valid_i      (s1_valid),
    .s1_ctl_i        (s1_ctl),
    .above_i         (above),
    .s1_fire_o       (s1_fire),
    .line_wdata_o    (line_wdata),
    .out_valid_o     (result_o.valid),
    .out_ready_i     (result_o.ready),
    .gold_total_o    (result_o.gold_total),
    .enclosed_gold_o (result_o.enclosed_gold)
  );

  // A result appears only from the grid's final cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> $past(s1_fire && s1_ctl.frame_end))
    else $error("result word without final cell");

  // Only the final cell may wait in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid && !s1_fire |-> s1_ctl.frame_end)
    else $error("non-final cell stalled");

  // Every enclosed cell is itself gold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (GOLD_W'(result_o.enclosed_gold) <= result_o.gold_total))
    else $error("enclosed count above gold count");

endmodule

/* hw/rtl/gecc_ram.sv */
// ----------------------------------------------------------------------------
// gecc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gecc_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/gecc_scan.sv */
// ----------------------------------------------------------------------------
// gecc_scan
// Size registers, raster position tracking and the input register.
// ----------------------------------------------------------------------------
module gecc_scan #(
  parameter int unsigned MAX_SIDE = gecc_pkg::MAX_SIDE_DEF,
  parameter int unsigned PW       = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [gecc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gecc_pkg::CFG_W-1:0]      cfg_data_i,
  // input words
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [gecc_pkg::VALUE_W-1:0]    cell_value_i,
  output logic [PW-1:0]                   rd_col_o,
  // input register toward the evaluator
  output logic                            s1_valid_o,
  output gecc_pkg::cell_ctl_t             s1_ctl_o,
  output logic [PW-1:0]                   s1_col_o,
  input  logic                            s1_fire_i
);
  import gecc_pkg::*;

  localparam int unsigned SW = $clog2(MAX_SIDE + 1);

  logic [CFG_W-1:0] rows_cfg_q, cols_cfg_q;
  logic [SW-1:0]    rows_eff, cols_eff;
  logic [PW-1:0]    row_q, col_q;
  logic             s1_valid_q;
  cell_ctl_t        s1_ctl_q;
  logic [PW-1:0]    s1_col_q;
  logic             in_fire;
  logic             last_col, last_row;

  function automatic logic [SW-1:0] eff_side(input logic [CFG_W-1:0] v);
    logic [SW-1:0] s;
    if (v == '0) begin
      s = SW'(1);
    end else if (32'(v) > 32'(MAX_SIDE)) begin
      s = SW'(MAX_SIDE);
    end else begin
      s = SW'(v);
    end
    return s;
  endfunction

  assign rows_eff = eff_side(rows_cfg_q);
  assign cols_eff = eff_side(cols_cfg_q);

  assign in_ready_o = !s1_valid_q || s1_fire_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign last_col   = (SW'(col_q) + SW'(1)) == cols_eff;
  assign last_row   = (SW'(row_q) + SW'(1)) == rows_eff;
  assign rd_col_o   = col_q;

  // Size registers and raster position; a size register write restarts the grid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= SIDE_RESET;
      cols_cfg_q <= SIDE_RESET;
      row_q      <= '0;
      col_q      <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_ROW_COUNT) begin
        rows_cfg_q <= cfg_data_i;
        row_q      <= '0;
        col_q      <= '0;
      end else if (cfg_index_i == REG_COLUMN_COUNT) begin
        cols_cfg_q <= cfg_data_i;
        row_q      <= '0;
        col_q      <= '0;
      end
    end else if (in_fire) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + PW'(1);
      end else begin
        col_q <= col_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Payload of the input register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ctl_q.gold      <= (cell_value_i == GOLD_VALUE);
      s1_ctl_q.interior  <= (SW'(row_q) >= SW'(2)) && (SW'(col_q) >= SW'(2));
      s1_ctl_q.row_end   <= last_col;
      s1_ctl_q.frame_end <= last_col && last_row;
      s1_col_q           <= col_q;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_ctl_o   = s1_ctl_q;
  assign s1_col_o   = s1_col_q;

endmodule

/* hw/rtl/gecc_eval.sv */
// ----------------------------------------------------------------------------
// gecc_eval
// Flag window, 3x3 test, saturating counters and the result register.
// ----------------------------------------------------------------------------
module gecc_eval (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         restart_i,
  input  logic                         s1_valid_i,
  input  gecc_pkg::cell_ctl_t          s1_ctl_i,
  input  logic [1:0]                   above_i,
  output logic                         s1_fire_o,
  output logic [1:0]                   line_wdata_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [gecc_pkg::GOLD_W-1:0]  gold_total_o,
  output logic [gecc_pkg::ENC_W-1:0]   enclosed_gold_o
);
  import gecc_pkg::*;

  logic [5:0]        window_q;
  logic [GOLD_W-1:0] gold_q, gold_d;
  logic [ENC_W-1:0]  enc_q, enc_d;
  logic              out_valid_q;
  logic [GOLD_W-1:0] gold_out_q;
  logic [ENC_W-1:0]  enc_out_q;
  logic [2:0]        column;
  logic              all_gold;
  logic              out_free;

  // bit0 = row r-2, bit1 = row r-1, bit2 = row r
  assign column   = {s1_ctl_i.gold, above_i[0], above_i[1]};
  assign all_gold = (&window_q) && (&column);

  assign gold_d = (s1_ctl_i.gold && gold_q != GOLD_MAX) ? gold_q + GOLD_W'(1) : gold_q;
  assign enc_d  = (s1_ctl_i.interior && all_gold && enc_q != ENC_MAX)
                  ? enc_q + ENC_W'(1) : enc_q;

  assign out_free     = !out_valid_q || out_ready_i;
  assign s1_fire_o    = s1_valid_i && (!s1_ctl_i.frame_end || out_free);
  // Age the line entry: row r-1 moves to r-2, current cell becomes r-1
  assign line_wdata_o = {above_i[0], s1_ctl_i.gold};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      gold_q   <= '0;
      enc_q    <= '0;
    end else if (restart_i) begin
      window_q <= '0;
      gold_q   <= '0;
      enc_q    <= '0;
    end else if (s1_fire_o) begin
      if (s1_ctl_i.frame_end) begin
        window_q <= '0;
        gold_q   <= '0;
        enc_q    <= '0;
      end else begin
        window_q <= s1_ctl_i.row_end ? 6'd0 : {window_q[2:0], column};
        gold_q   <= gold_d;
        enc_q    <= enc_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire_o && s1_ctl_i.frame_end) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire_o && s1_ctl_i.frame_end) begin
      gold_out_q <= gold_d;
      enc_out_q  <= enc_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign gold_total_o    = gold_out_q;
  assign enclosed_gold_o = enc_out_q;

endmodule

/* tb/grid_enclosed_cell_counter_tb.sv */
// ----------------------------------------------------------------------------
// grid_enclosed_cell_counter_tb
// Streams raster grids of assorted sizes and gold densities into the counter.
// Predicts the gold and enclosed-gold counts of every grid and checks each
// result word, with random idling on both channels and one long result stall.
// ----------------------------------------------------------------------------
module grid_enclosed_cell_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gecc_pkg::*;

  localparam int unsigned MAX_SIDE      = MAX_SIDE_DEF;
  localparam int unsigned ITEM_TARGET   = 1850;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // Indexes that decode to no register: a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // Percentage of gold cells in a grid; the high ones make enclosed cells likely
  localparam int unsigned DENSITY_CHOICES [5] = '{0, 50, 90, 97, 100};

  typedef struct packed {
    logic [GOLD_W-1:0] gold_total;
    logic [ENC_W-1:0]  enclosed_gold;
  } grid_counts_t;

  // --------------------------------------------------------------------------
  // Clock, reset and channel drive registers
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 cfg_valid    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = REG_ROW_COUNT;
  logic [CFG_W-1:0]     cfg_data     = '0;
  logic                 cell_valid   = 1'b0;
  logic [VALUE_W-1:0]   cell_value   = '0;
  logic                 result_ready = 1'b0;

  // Long receiver hold-off, armed once by the stimulus and timed by its own process
  logic        hold_req = 1'b0;
  logic        hold_done;
  int unsigned hold_count;
  logic        hold_active;

  // Idle bursts: 0 odds disable them; else one-in-N per sent word or ready update
  int unsigned send_gap;
  int unsigned recv_stall;
  int unsigned send_idle_odds = 3;
  int unsigned recv_idle_odds = 3;

  int unsigned cells_queued = 0;
  int unsigned error_count  = 0;

  logic [VALUE_W-1:0] pending_cells [$];
  grid_counts_t       expected_counts [$];

  // Predictor copy of the block state
  logic [CFG_W-1:0]   row_size;
  logic [CFG_W-1:0]   col_size;
  logic [1:0]         flag_line [MAX_SIDE];  // bit0: row above, bit1: two rows above
  logic [5:0]         window_flags;          // two previous 3-high flag columns
  int unsigned        row_pos;
  int unsigned        col_pos;
  logic [GOLD_W-1:0]  gold_cnt;
  logic [ENC_W-1:0]   enc_cnt;

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Interfaces and the block
  // --------------------------------------------------------------------------
  gecc_cfg_if    cfg_bus ();
  gecc_cell_if   cell_bus ();
  gecc_result_if result_bus ();

  assign cfg_bus.valid       = cfg_valid;
  assign cfg_bus.index       = cfg_index;
  assign cfg_bus.data        = cfg_data;
  assign cell_bus.valid      = cell_valid;
  assign cell_bus.cell_value = cell_value;
  assign result_bus.ready    = result_ready;

  grid_enclosed_cell_counter #(
    .MAX_SIDE (MAX_SIDE)
  ) DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .cell_i   (cell_bus),
    .result_o (result_bus)
  );

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // Clamp a size register: zero acts as one, anything past the line store
  // acts as its full width.
  function automatic int unsigned side_of(input logic [CFG_W-1:0] value);
    if (value == '0) return 1;
    if (value > MAX_SIDE) return MAX_SIDE;
    return 32'(value);
  endfunction

  function automatic void restart_grid_counts();
    window_flags = '0;
    row_pos      = 0;
    col_pos      = 0;
    gold_cnt     = '0;
    enc_cnt      = '0;
  endfunction

  // Any write to a real size register also throws away the grid in progress
  function automatic void apply_size_write(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_W-1:0]     value);
    case (idx)
      REG_ROW_COUNT: begin
        row_size = value;
        restart_grid_counts();
      end
      REG_COLUMN_COUNT: begin
        col_size = value;
        restart_grid_counts();
      end
      default: ;
    endcase
  endfunction

  // Advance the grid by one cell; return 1 with the counts on the final cell
  function automatic bit count_cell(input  logic [VALUE_W-1:0] value,
                                    output grid_counts_t       counts);
    int unsigned rows;
    int unsigned cols;
    int unsigned r;
    int unsigned c;
    logic        cur;
    logic [1:0]  above;
    logic [2:0]  column;
    rows   = side_of(row_size);
    cols   = side_of(col_size);
    r      = (row_pos >= rows) ? 0 : row_pos;
    c      = (col_pos >= cols) ? 0 : col_pos;
    counts = '0;

    cur    = (value == GOLD_VALUE);
    above  = flag_line[c];
    // Stack the column oldest row first: two above, one above, this row
    column = {cur, above[0], above[1]};

    if (cur && gold_cnt < GOLD_MAX) gold_cnt = gold_cnt + 1'b1;
    // The window centre sits one up and one left of this cell
    if (r >= 2 && c >= 2 && (&{window_flags, column}) && enc_cnt < ENC_MAX) begin
      enc_cnt = enc_cnt + 1'b1;
    end

    window_flags = {window_flags[2:0], column};
    flag_line[c] = {above[0], cur};

    if (c + 1 < cols) begin
      col_pos = c + 1;
      row_pos = r;
      return 1'b0;
    end
    col_pos      = 0;
    window_flags = '0;
    if (r + 1 < rows) begin
      row_pos = r + 1;
      return 1'b0;
    end

    counts.gold_total    = gold_cnt;
    counts.enclosed_gold = enc_cnt;
    restart_grid_counts();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Cell driver: offer queued cells, idling in bursts after some words
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : cell_driver
    if (!rst_ni) begin
      cell_valid <= 1'b0;
      cell_value <= '0;
      send_gap   <= 0;
    end else if (!cell_valid || cell_bus.ready) begin
      if (send_gap != 0) begin
        // Drop valid for the rest of the burst
        send_gap   <= send_gap - 1;
        cell_valid <= 1'b0;
      end else if (pending_cells.size() != 0) begin
        cell_valid <= 1'b1;
        cell_value <= pending_cells.pop_front();
        if (send_idle_odds != 0 && $urandom_range(1, send_idle_odds) == 1) begin
          send_gap <= $urandom_range(1, 7);
        end
      end else begin
        cell_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long hold-off of the result channel, counted here once armed
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : result_hold
    if (!rst_ni) begin
      hold_count <= 0;
      hold_done  <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_count <= hold_count + 1;
      if (hold_count + 1 == HOLD_CYCLES) hold_done <= 1'b1;
    end
  end

  assign hold_active = hold_req && !hold_done;

  // --------------------------------------------------------------------------
  // Monitor: check result words, track config writes and accepted cells,
  // and drive result ready.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    grid_counts_t got;
    grid_counts_t want;
    int unsigned  next_stall;
    if (!rst_ni) begin
      result_ready <= 1'b0;
      recv_stall   <= 0;
      row_size     = SIDE_RESET;
      col_size     = SIDE_RESET;
      foreach (flag_line[i]) flag_line[i] = '0;
      restart_grid_counts();
    end else begin
      // Check first: a result word always trails the cell that caused it
      if (result_bus.valid && result_ready) begin
        got.gold_total    = result_bus.gold_total;
        got.enclosed_gold = result_bus.enclosed_gold;
        if (expected_counts.size() == 0) begin
          report_mismatch($sformatf("unexpected result word gold_total=%0d enclosed_gold=%0d",
                                    got.gold_total, got.enclosed_gold));
        end else begin
          want = expected_counts.pop_front();
          if (got.gold_total !== want.gold_total) begin
            report_mismatch($sformatf("gold_total got %0d expected %0d",
                                      got.gold_total, want.gold_total));
          end
          if (got.enclosed_gold !== want.enclosed_gold) begin
            report_mismatch($sformatf("enclosed_gold got %0d expected %0d",
                                      got.enclosed_gold, want.enclosed_gold));
          end
        end
      end

      if (cfg_valid && cfg_bus.ready) apply_size_write(cfg_index, cfg_data);

      if (cell_valid && cell_bus.ready) begin
        if (count_cell(cell_value, want)) expected_counts.push_back(want);
      end

      // Hold ready low during a stall burst or the long hold-off
      next_stall = recv_stall;
      if (next_stall != 0) begin
        next_stall--;
      end else if (recv_idle_odds != 0 && $urandom_range(1, recv_idle_odds) == 1) begin
        next_stall = $urandom_range(1, 7);
      end
      recv_stall   <= next_stall;
      result_ready <= (next_stall == 0) && !hold_active;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Write one register and hold the word until the channel takes it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued cell is in and every result word is out, then let
  // the pipeline settle so a trailing partial grid is fully absorbed.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_cells.size() != 0 || cell_valid || expected_counts.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic queue_cells(input int unsigned count, input int unsigned density);
    logic [VALUE_W-1:0] value;
    repeat (count) begin
      if ($urandom_range(0, 99) < density) begin
        value = GOLD_VALUE;
      end else begin
        do value = VALUE_W'($urandom_range(0, 255)); while (value == GOLD_VALUE);
      end
      pending_cells.push_back(value);
      cells_queued++;
    end
  endtask

  // Mostly small sides; now and then any 6-bit value, zero and oversize included
  function automatic logic [CFG_W-1:0] random_side();
    if ($urandom_range(0, 7) == 0) return CFG_W'($urandom_range(0, 63));
    return CFG_W'($urandom_range(1, 8));
  endfunction

  // Set the grid size, then stream whole grids and optionally a cut-off grid
  // that the next size write abandons.
  task automatic run_phase(input logic [CFG_W-1:0] rows_w, input logic [CFG_W-1:0] cols_w,
                           input int unsigned grids, input bit add_tail);
    int unsigned cells_per_grid;
    wait_idle();
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_ROW_COUNT, rows_w);
      write_reg(REG_COLUMN_COUNT, cols_w);
    end else begin
      write_reg(REG_COLUMN_COUNT, cols_w);
      write_reg(REG_ROW_COUNT, rows_w);
    end
    if ($urandom_range(0, 5) == 0) begin
      write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_2 : REG_SPARE_3,
                CFG_W'($urandom_range(0, 63)));
    end
    cells_per_grid = side_of(rows_w) * side_of(cols_w);
    @(negedge clk_i);
    repeat (grids) queue_cells(cells_per_grid, DENSITY_CHOICES[$urandom_range(0, 4)]);
    if (add_tail && cells_per_grid > 1) begin
      queue_cells($urandom_range(1, cells_per_grid - 1), DENSITY_CHOICES[$urandom_range(0, 4)]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [CFG_W-1:0] rows_w;
    logic [CFG_W-1:0] cols_w;
    int unsigned      n_grids;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero sizes act as a 1 x 1 grid: each cell is a grid of its own
    wait_idle();
    write_reg(REG_ROW_COUNT, '0);
    write_reg(REG_COLUMN_COUNT, '0);
    @(negedge clk_i);
    pending_cells.push_back(GOLD_VALUE);
    pending_cells.push_back('0);
    pending_cells.push_back({VALUE_W{1'b1}});

    // A write to an undecoded index must leave the 1 x 1 size in place
    wait_idle();
    write_reg(REG_SPARE_2, {CFG_W{1'b1}});
    @(negedge clk_i);
    pending_cells.push_back(GOLD_VALUE);

    // Smallest grid with an interior: all gold, then one near-miss corner
    wait_idle();
    write_reg(REG_ROW_COUNT, 6'd3);
    write_reg(REG_COLUMN_COUNT, 6'd3);
    @(negedge clk_i);
    queue_cells(9, 100);
    pending_cells.push_back(GOLD_VALUE - 1'b1);
    queue_cells(8, 100);

    // Two rows: no interior however much gold
    wait_idle();
    write_reg(REG_ROW_COUNT, 6'd2);
    @(negedge clk_i);
    queue_cells(6, 100);

    // Random part, opening with the size extremes
    cells_queued = 0;
    run_phase(6'd63, 6'd1, 2, 1'b0);
    run_phase(6'd1, 6'd32, 2, 1'b0);
    run_phase(6'd2, 6'd33, 1, 1'b1);

    // Every cell ends a 1 x 1 grid; hold the result channel off so the block
    // backs up and stalls its cell input while cells keep coming.
    wait_idle();
    write_reg(REG_ROW_COUNT, 6'd1);
    write_reg(REG_COLUMN_COUNT, 6'd1);
    hold_req <= 1'b1;
    @(negedge clk_i);
    queue_cells(150, 50);

    run_phase(6'd32, 6'd32, 1, 1'b0);

    while (cells_queued < ITEM_TARGET) begin
      rows_w = random_side();
      cols_w = random_side();
      if (cells_queued + 250 > ITEM_TARGET) begin
        // Run the tail at full rate on both sides
        send_idle_odds = 0;
        recv_idle_odds = 0;
      end else begin
        send_idle_odds = $urandom_range(0, 3) * 2;
        recv_idle_odds = $urandom_range(0, 3) * 2;
      end
      // Keep a large grid from running far past the item budget
      if (cells_queued + side_of(rows_w) * side_of(cols_w) > ITEM_TARGET) begin
        rows_w = CFG_W'($urandom_range(1, 8));
        cols_w = CFG_W'($urandom_range(1, 8));
      end
      n_grids = $urandom_range(1, 4);
      while (n_grids > 1 &&
             cells_queued + n_grids * side_of(rows_w) * side_of(cols_w) > ITEM_TARGET) begin
        n_grids--;
      end
      run_phase(rows_w, cols_w, n_grids, $urandom_range(0, 3) == 0);
    end

    wait_idle();
    repeat (2 * SETTLE_CYCLES) @(negedge clk_i);
    if (expected_counts.size() != 0) begin
      $display("ERROR: %0d result words never arrived", expected_counts.size());
    end
    if (error_count == 0 && expected_counts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: end the run if the stream never drains
  initial begin : watchdog
    int unsigned cycles_run;
    cycles_run = 0;
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles_run++;
    end
    $display("ERROR: timeout after %0d cycles", CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
